// ===== hw/rtl/ffpa_pkg.sv =====
`timescale 1ns / 1ps

package ffpa_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_RUN   = 2'd1,
    STATUS_ZERO     = 2'd2,
    STATUS_BAD_FREE = 2'd3
  } status_t;

  // Request operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Fixed field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 9;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DIV,
    S_FREAD,
    S_FCHK,
    S_RELEASE,
    S_RESULT
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_SCAN,
    DP_MARK,
    DP_DIV,
    DP_FREAD,
    DP_FCHK,
    DP_RELEASE,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    accept;
    logic    load_res;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic clear_done;
    logic scan_hit;
    logic scan_fail;
    logic mark_done;
    logic div_done;
    logic free_ok;
    logic rel_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/first_fit_page_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       request    in_valid / in_stall     in_func, in_size_bytes, in_address
// out_      result     out_valid / out_stall   out_status, out_run_address,
//                                              out_pages_used, out_pages_peak
// cfg_      register   cfg_wr_en               cfg_wr_data (pool base)
//
// Allocate: a one-page-a-cycle page table scan up to the first fitting run (or to the last page
// of the pool on failure), marking of the run's pages, then the result. Zero-size allocate:
// straight to the result. Free: a reciprocal page-index division and alignment check, a page
// table read and check, release of the run's pages, then the result. One request is worked on
// at a time. After reset a clearing pass frees every page; in_stall is high meanwhile.
// A waiting result does not block the next request; a finished one waits for the out slot.

module first_fit_page_allocator #(
  parameter int unsigned NUM_PAGES  = 256,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_size_bytes,
  input  logic [31:0] in_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_run_address,
  output logic [8:0]  out_pages_used,
  output logic [8:0]  out_pages_peak,
  // pool base register
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // controller <-> datapath
  ffpa_pkg::dp_cmd_t  cmd;
  ffpa_pkg::dp_stat_t stat;

  // sequencer: clearing pass, scan, mark, divide, release, result hand-off
  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // page table memory, run search, offset divider, counters, result register
  ffpa_dpath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (in_func),
    .in_size_bytes   (in_size_bytes),
    .in_address      (in_address),
    .out_status      (out_status),
    .out_run_address (out_run_address),
    .out_pages_used  (out_pages_used),
    .out_pages_peak  (out_pages_peak)
  );

endmodule

// ===== hw/rtl/ffpa_dpath.sv =====
`timescale 1ns / 1ps

module ffpa_dpath #(
  parameter int unsigned NUM_PAGES  = 256,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ffpa_pkg::dp_cmd_t        cmd,
  output ffpa_pkg::dp_stat_t       stat,
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data,
  input  logic                     in_func,
  input  logic [31:0]              in_size_bytes,
  input  logic [31:0]              in_address,
  output logic [1:0]               out_status,
  output logic [31:0]              out_run_address,
  output logic [8:0]               out_pages_used,
  output logic [8:0]               out_pages_peak
);

  localparam int unsigned PW     = $clog2(NUM_PAGES);
  localparam int unsigned LW     = $clog2(NUM_PAGES + 1);
  localparam int unsigned PB_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned SH     = 32 + PB_LOG;

  // ceil(2^SH / PAGE_BYTES): exact quotient for every 32-bit offset
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) /
                                       64'(PAGE_BYTES);
  localparam logic [32:0] RECIP      = RECIP_FULL[32:0];

  localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);
  localparam logic [32:0]   PB_SUM    = 33'(PAGE_BYTES);
  localparam logic [31:0]   PB_OFF    = 32'(PAGE_BYTES);
  localparam logic [31:0]   NUM_Q     = 32'(NUM_PAGES);
  localparam logic [LW-1:0] NUM_CNT   = LW'(NUM_PAGES);
  localparam logic [1:0]    DIV_LAST  = 2'd2;

  // page table: {busy, run length}
  logic [LW:0]    mem_r [NUM_PAGES];
  logic           mem_we;
  logic [PW-1:0]  mem_waddr;
  logic [PW-1:0]  mem_raddr;
  logic [LW:0]    mem_wdata;
  logic [LW:0]    rdata_r;

  logic [31:0]    pool_base_r;
  logic           func_r,      func_nxt;
  logic [31:0]    size_r,      size_nxt;
  logic [PW-1:0]  ptr_r,       ptr_nxt;
  logic [PW-1:0]  chk_ptr_r,   chk_ptr_nxt;
  logic           chk_v_r,     chk_v_nxt;
  logic [PW-1:0]  start_r,     start_nxt;
  logic [31:0]    start_off_r, start_off_nxt;
  logic [31:0]    cur_off_r,   cur_off_nxt;
  logic [LW-1:0]  found_r,     found_nxt;
  logic [LW-1:0]  remain_r,    remain_nxt;
  logic [32:0]    run_bytes_r, run_bytes_nxt;
  logic [31:0]    num_r,       num_nxt;
  logic [64:0]    prod_r,      prod_nxt;
  logic           misalign_r,  misalign_nxt;
  logic [31:0]    q_r,         q_nxt;
  logic [1:0]     cnt_r,       cnt_nxt;
  logic [LW-1:0]  used_r,      used_nxt;
  logic [LW-1:0]  peak_r,      peak_nxt;

  logic [1:0]     out_status_r;
  logic [31:0]    out_addr_r;
  logic [8:0]     out_used_r;
  logic [8:0]     out_peak_r;

  logic           busy_bit;
  logic [LW-1:0]  run_len;
  logic [32:0]    run_sum;
  logic [LW-1:0]  found_inc;
  logic           scan_fit;
  logic           scan_end;
  logic [PW-1:0]  run_start;
  logic [LW-1:0]  used_sum;
  logic           range_ok;
  logic           free_ok;
  logic           rel_done;
  logic [31:0]    res_addr;
  logic [LW+8:0]  used_ext;
  logic [LW+8:0]  peak_ext;

  assign busy_bit  = rdata_r[LW];
  assign run_len   = rdata_r[LW-1:0];
  assign run_sum   = ((found_r == '0) ? 33'd0 : run_bytes_r) + PB_SUM;
  assign found_inc = found_r + LW'(1);
  assign scan_fit  = chk_v_r && !busy_bit && (run_sum >= {1'b0, size_r});
  assign scan_end  = chk_v_r && (chk_ptr_r == LAST_PAGE) && !scan_fit;
  assign run_start = (found_r == '0) ? chk_ptr_r : start_r;
  assign used_sum  = used_r + found_r;
  assign range_ok  = !misalign_r && (q_r < NUM_Q);
  assign free_ok   = range_ok && busy_bit && (run_len != '0);
  assign rel_done  = (remain_r == LW'(1)) || (ptr_r == LAST_PAGE);

  assign stat.is_free    = (in_func == ffpa_pkg::FUNC_FREE);
  assign stat.size_zero  = (in_size_bytes == '0);
  assign stat.clear_done = (ptr_r == LAST_PAGE);
  assign stat.scan_hit   = scan_fit;
  assign stat.scan_fail  = scan_end;
  assign stat.mark_done  = (remain_r == LW'(1));
  assign stat.div_done   = (cnt_r == DIV_LAST);
  assign stat.free_ok    = free_ok;
  assign stat.rel_done   = rel_done;

  always_comb begin
    func_nxt      = func_r;
    size_nxt      = size_r;
    ptr_nxt       = ptr_r;
    chk_ptr_nxt   = chk_ptr_r;
    chk_v_nxt     = chk_v_r;
    start_nxt     = start_r;
    start_off_nxt = start_off_r;
    cur_off_nxt   = cur_off_r;
    found_nxt     = found_r;
    remain_nxt    = remain_r;
    run_bytes_nxt = run_bytes_r;
    num_nxt       = num_r;
    prod_nxt      = prod_r;
    misalign_nxt  = misalign_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    peak_nxt      = peak_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = '0;
    mem_raddr     = ptr_r;
    unique case (cmd.op)
      ffpa_pkg::DP_IDLE: begin
        if (cmd.accept) begin
          func_nxt      = in_func;
          size_nxt      = in_size_bytes;
          num_nxt       = in_address - pool_base_r;
          misalign_nxt  = 1'b0;
          q_nxt         = '0;
          cnt_nxt       = '0;
          ptr_nxt       = '0;
          chk_v_nxt     = 1'b0;
          found_nxt     = '0;
          cur_off_nxt   = '0;
          run_bytes_nxt = '0;
        end
      end
      ffpa_pkg::DP_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = (ptr_r == LAST_PAGE) ? '0 : ptr_r + PW'(1);
      end
      ffpa_pkg::DP_SCAN: begin
        // read issued for ptr, data for chk_ptr arrives in the next cycle
        ptr_nxt     = (ptr_r == LAST_PAGE) ? ptr_r : ptr_r + PW'(1);
        chk_ptr_nxt = ptr_r;
        chk_v_nxt   = 1'b1;
        if (chk_v_r) begin
          cur_off_nxt = cur_off_r + PB_OFF;
          if (busy_bit) begin
            found_nxt = '0;
          end else begin
            if (found_r == '0) begin
              start_nxt     = chk_ptr_r;
              start_off_nxt = cur_off_r;
            end
            found_nxt     = found_inc;
            run_bytes_nxt = run_sum;
            if (scan_fit) begin
              ptr_nxt    = run_start;
              remain_nxt = found_inc;
            end
          end
        end
      end
      ffpa_pkg::DP_MARK: begin
        mem_we     = 1'b1;
        mem_wdata  = {1'b1, (ptr_r == start_r) ? found_r : LW'(0)};
        ptr_nxt    = ptr_r + PW'(1);
        remain_nxt = remain_r - LW'(1);
        if (remain_r == LW'(1)) begin
          used_nxt = used_sum;
          if (used_sum > peak_r) begin
            peak_nxt = used_sum;
          end
        end
      end
      ffpa_pkg::DP_DIV: begin
        // page index by reciprocal multiply, then an alignment check
        unique case (cnt_r)
          2'd0: begin
            prod_nxt = 65'(num_r) * 65'(RECIP);
          end
          2'd1: begin
            q_nxt = 32'(prod_r >> SH);
          end
          default: begin
            misalign_nxt = (num_r != q_r * PB_OFF);
          end
        endcase
        cnt_nxt = cnt_r + 2'd1;
      end
      ffpa_pkg::DP_FREAD: begin
        mem_raddr = q_r[PW-1:0];
      end
      ffpa_pkg::DP_FCHK: begin
        if (free_ok) begin
          ptr_nxt    = q_r[PW-1:0];
          remain_nxt = run_len;
          found_nxt  = run_len;
        end
      end
      ffpa_pkg::DP_RELEASE: begin
        mem_we     = 1'b1;
        ptr_nxt    = ptr_r + PW'(1);
        remain_nxt = remain_r - LW'(1);
        if (rel_done) begin
          used_nxt = (used_r >= found_r) ? used_r - found_r : '0;
        end
      end
      ffpa_pkg::DP_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign res_addr = ((cmd.res_status == ffpa_pkg::STATUS_OK) &&
                     (func_r == ffpa_pkg::FUNC_ALLOC)) ? pool_base_r + start_off_r : '0;
  assign used_ext = {{9{1'b0}}, used_r};
  assign peak_ext = {{9{1'b0}}, peak_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      ptr_r       <= '0;
      chk_v_r     <= 1'b0;
      used_r      <= '0;
      peak_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        pool_base_r <= cfg_wr_data;
      end
      ptr_r   <= ptr_nxt;
      chk_v_r <= chk_v_nxt;
      used_r  <= used_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    size_r      <= size_nxt;
    chk_ptr_r   <= chk_ptr_nxt;
    start_r     <= start_nxt;
    start_off_r <= start_off_nxt;
    cur_off_r   <= cur_off_nxt;
    found_r     <= found_nxt;
    remain_r    <= remain_nxt;
    run_bytes_r <= run_bytes_nxt;
    num_r       <= num_nxt;
    prod_r      <= prod_nxt;
    misalign_r  <= misalign_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    if (cmd.load_res) begin
      out_status_r <= cmd.res_status;
      out_addr_r   <= res_addr;
      out_used_r   <= used_ext[8:0];
      out_peak_r   <= peak_ext[8:0];
    end
  end

  assign out_status      = out_status_r;
  assign out_run_address = out_addr_r;
  assign out_pages_used  = out_used_r;
  assign out_pages_peak  = out_peak_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NUM_CNT)
    else $error("used page count above pool size");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= used_r)
    else $error("peak below current use");

  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ffpa_pkg::DP_MARK) && (remain_r == LW'(1)) |=>
      used_r == $past(used_r) + $past(found_r))
    else $error("used count not raised by run length");
`endif

endmodule

// ===== hw/rtl/ffpa_ctrl.sv =====
`timescale 1ns / 1ps

module ffpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ffpa_pkg::dp_stat_t  stat,
  output ffpa_pkg::dp_cmd_t   cmd
);

  ffpa_pkg::state_t  state_r,      state_nxt;
  ffpa_pkg::status_t res_status_r, res_status_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      ffpa_pkg::S_CLEAR: begin
        if (stat.clear_done) state_nxt = ffpa_pkg::S_IDLE;
      end
      ffpa_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (stat.is_free) begin
            state_nxt = ffpa_pkg::S_DIV;
          end else if (stat.size_zero) begin
            state_nxt      = ffpa_pkg::S_RESULT;
            res_status_nxt = ffpa_pkg::STATUS_ZERO;
          end else begin
            state_nxt = ffpa_pkg::S_SCAN;
          end
        end
      end
      ffpa_pkg::S_SCAN: begin
        priority if (stat.scan_hit) begin
          state_nxt = ffpa_pkg::S_MARK;
        end else if (stat.scan_fail) begin
          state_nxt      = ffpa_pkg::S_RESULT;
          res_status_nxt = ffpa_pkg::STATUS_NO_RUN;
        end else begin
          state_nxt = ffpa_pkg::S_SCAN;
        end
      end
      ffpa_pkg::S_MARK: begin
        if (stat.mark_done) begin
          state_nxt      = ffpa_pkg::S_RESULT;
          res_status_nxt = ffpa_pkg::STATUS_OK;
        end
      end
      ffpa_pkg::S_DIV: begin
        if (stat.div_done) state_nxt = ffpa_pkg::S_FREAD;
      end
      ffpa_pkg::S_FREAD: begin
        state_nxt = ffpa_pkg::S_FCHK;
      end
      ffpa_pkg::S_FCHK: begin
        if (stat.free_ok) begin
          state_nxt = ffpa_pkg::S_RELEASE;
        end else begin
          state_nxt      = ffpa_pkg::S_RESULT;
          res_status_nxt = ffpa_pkg::STATUS_BAD_FREE;
        end
      end
      ffpa_pkg::S_RELEASE: begin
        if (stat.rel_done) begin
          state_nxt      = ffpa_pkg::S_RESULT;
          res_status_nxt = ffpa_pkg::STATUS_OK;
        end
      end
      ffpa_pkg::S_RESULT: begin
        if (out_free) state_nxt = ffpa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffpa_pkg::S_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall       = (state_r != ffpa_pkg::S_IDLE);
    cmd.accept     = (state_r == ffpa_pkg::S_IDLE) && in_valid;
    cmd.load_res   = (state_r == ffpa_pkg::S_RESULT) && out_free;
    cmd.res_status = res_status_r;
    unique case (state_r)
      ffpa_pkg::S_CLEAR:   cmd.op = ffpa_pkg::DP_CLEAR;
      ffpa_pkg::S_IDLE:    cmd.op = ffpa_pkg::DP_IDLE;
      ffpa_pkg::S_SCAN:    cmd.op = ffpa_pkg::DP_SCAN;
      ffpa_pkg::S_MARK:    cmd.op = ffpa_pkg::DP_MARK;
      ffpa_pkg::S_DIV:     cmd.op = ffpa_pkg::DP_DIV;
      ffpa_pkg::S_FREAD:   cmd.op = ffpa_pkg::DP_FREAD;
      ffpa_pkg::S_FCHK:    cmd.op = ffpa_pkg::DP_FCHK;
      ffpa_pkg::S_RELEASE: cmd.op = ffpa_pkg::DP_RELEASE;
      ffpa_pkg::S_RESULT:  cmd.op = ffpa_pkg::DP_RESULT;
      default:             cmd.op = ffpa_pkg::DP_IDLE;
    endcase
    out_valid_nxt = cmd.load_res || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffpa_pkg::S_CLEAR;
      res_status_r <= ffpa_pkg::STATUS_OK;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ffpa_pkg::S_RESULT)
    else $error("result raised outside result state");

  a_mark_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffpa_pkg::S_MARK |->
      $past(state_r) == ffpa_pkg::S_SCAN || $past(state_r) == ffpa_pkg::S_MARK)
    else $error("marking entered without a found run");

  a_release_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffpa_pkg::S_RELEASE |->
      $past(state_r) == ffpa_pkg::S_FCHK || $past(state_r) == ffpa_pkg::S_RELEASE)
    else $error("release entered without a checked run");
`endif

endmodule
